[src/mkpq_pkg.sv]
// Shared types, codes and defaults of the min-key priority queue.
package mkpq_pkg;

	localparam int DEPTH_DEF = 8;

	localparam int OP_W     = 2;
	localparam int TOKEN_W  = 16;
	localparam int AGE_W    = 7;
	localparam int ID_W     = 16;
	localparam int STATUS_W = 2;
	localparam int SAME_W   = 3;

	localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
	localparam logic [OP_W-1:0] OP_TRAV  = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [SAME_W-1:0] SAME_MAX = 3'd7;

	typedef struct packed {
		logic [TOKEN_W-1:0] token;
		logic [AGE_W-1:0]   age;
		logic [ID_W-1:0]    name_id;
		logic [ID_W-1:0]    problem_id;
	} record_t;

endpackage

[src/min_key_priority_queue_unit.sv]
// Top level of the min-key priority queue: record memory, pointers and sequencer.
//
// Usage: commands arrive on the input channel (in_valid / in_ready) with the
// fields operation, token, age, name_id and problem_id. Results leave on the
// output channel (out_valid / out_ready), one transfer per result.
// Enqueue inserts a record in ascending token order behind all records with an
// equal or smaller token and answers with one transfer (ok or full). Dequeue
// answers with the record of smallest token (or empty). Traverse emits every
// held record in order with the count of later records sharing its problem id,
// saturated at 7, and raises last on the final one. Operation code 3 is dropped.
// The records live in a single-port-read, single-port-write memory with a
// registered read, organized as a sorted circular buffer: dequeue only
// moves the head pointer, enqueue shifts the tail one record at a time.
// A new command is taken only when the sequencer is idle, which it may be while
// a result still waits in the output register; a stalled receiver holds the
// sequencer only when it has the next result ready. Reset empties the queue at
// once; the memory is not cleared, since no unwritten entry is ever read.
module min_key_priority_queue_unit #(
	parameter int DEPTH = mkpq_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mkpq_pkg::OP_W-1:0]     operation,
	input  logic [mkpq_pkg::TOKEN_W-1:0]  token,
	input  logic [mkpq_pkg::AGE_W-1:0]    age,
	input  logic [mkpq_pkg::ID_W-1:0]     name_id,
	input  logic [mkpq_pkg::ID_W-1:0]     problem_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mkpq_pkg::STATUS_W-1:0] status,
	output logic [mkpq_pkg::TOKEN_W-1:0]  out_token,
	output logic [mkpq_pkg::AGE_W-1:0]    out_age,
	output logic [mkpq_pkg::ID_W-1:0]     out_name_id,
	output logic [mkpq_pkg::ID_W-1:0]     out_problem_id,
	output logic [mkpq_pkg::SAME_W-1:0]   same_problem_later,
	output logic                          last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_EMIT     = 4'd1;
	localparam logic [3:0] S_ENQ_RD   = 4'd2;
	localparam logic [3:0] S_ENQ_CMP  = 4'd3;
	localparam logic [3:0] S_ENQ_WR   = 4'd4;
	localparam logic [3:0] S_DEQ_WAIT = 4'd5;
	localparam logic [3:0] S_TR_RD    = 4'd6;
	localparam logic [3:0] S_TR_CUR   = 4'd7;
	localparam logic [3:0] S_TR_SCAN  = 4'd8;
	localparam logic [3:0] S_TR_OUT   = 4'd9;

	// Map a position in sorted order onto a memory address.
	function automatic logic [IW-1:0] phys(input logic [IW-1:0] hd, input logic [IW-1:0] lg);
		logic [IW:0] s;
		s = {1'b0, hd} + {1'b0, lg};
		if (s >= (IW+1)'(DEPTH)) begin
			s = s - (IW+1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	// Record memory.
	mkpq_pkg::record_t mem [DEPTH];
	mkpq_pkg::record_t rd_data_q;
	logic              rd_en, wr_en;
	logic [IW-1:0]     rd_addr, wr_addr;
	mkpq_pkg::record_t wr_data;

	// Control and working registers.
	logic [3:0]                    state_q;
	logic [IW-1:0]                 head_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 pos_q;
	logic [CW-1:0]                 i_q;
	logic [CW-1:0]                 j_q;
	logic                          rdv_q;
	logic [mkpq_pkg::SAME_W-1:0]   cnt_q;
	mkpq_pkg::record_t             new_q;
	mkpq_pkg::record_t             cur_q;
	mkpq_pkg::record_t             res_rec_q;
	logic [mkpq_pkg::STATUS_W-1:0] res_status_q;

	// Output register.
	logic                          out_valid_q;
	logic [mkpq_pkg::STATUS_W-1:0] status_q;
	mkpq_pkg::record_t             out_rec_q;
	logic [mkpq_pkg::SAME_W-1:0]   same_q;
	logic                          last_q;

	logic          in_fire;
	logic          out_free;
	logic          out_load;
	logic [CW-1:0] pos_m1;
	logic [CW-1:0] i_p1;
	logic          tr_last;
	logic          shift_more;
	logic          same_hit;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign out_load   = ((state_q == S_EMIT) || (state_q == S_TR_OUT)) && out_free;
	assign pos_m1     = pos_q - CW'(1);
	assign i_p1       = i_q + CW'(1);
	assign tr_last    = (i_p1 == count_q);
	assign shift_more = (rd_data_q.token > new_q.token);
	assign same_hit   = rdv_q && (rd_data_q.problem_id == cur_q.problem_id);

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = phys(head_q, pos_q[IW-1:0]);
		wr_data = new_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && operation == mkpq_pkg::OP_DEQ && count_q != '0) begin
					rd_en = 1'b1;
				end
			end
			S_ENQ_RD: begin
				rd_en   = 1'b1;
				rd_addr = phys(head_q, pos_m1[IW-1:0]);
			end
			S_ENQ_CMP: begin
				if (shift_more) begin
					wr_en   = 1'b1;
					wr_data = rd_data_q;
				end
			end
			S_ENQ_WR: begin
				wr_en = 1'b1;
			end
			S_TR_RD: begin
				rd_en   = 1'b1;
				rd_addr = phys(head_q, i_q[IW-1:0]);
			end
			S_TR_SCAN: begin
				if (j_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = phys(head_q, j_q[IW-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			rdv_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						res_rec_q    <= '0;
						res_status_q <= mkpq_pkg::ST_OK;
						case (operation)
							mkpq_pkg::OP_ENQ: begin
								if (count_q == CW'(DEPTH)) begin
									res_status_q <= mkpq_pkg::ST_FULL;
									state_q      <= S_EMIT;
								end else begin
									new_q   <= '{token, age, name_id, problem_id};
									pos_q   <= count_q;
									state_q <= (count_q == '0) ? S_ENQ_WR : S_ENQ_RD;
								end
							end
							mkpq_pkg::OP_DEQ: begin
								if (count_q == '0) begin
									res_status_q <= mkpq_pkg::ST_EMPTY;
									state_q      <= S_EMIT;
								end else begin
									state_q <= S_DEQ_WAIT;
								end
							end
							mkpq_pkg::OP_TRAV: begin
								if (count_q == '0) begin
									res_status_q <= mkpq_pkg::ST_EMPTY;
									state_q      <= S_EMIT;
								end else begin
									i_q     <= '0;
									state_q <= S_TR_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_ENQ_RD: begin
					state_q <= S_ENQ_CMP;
				end
				S_ENQ_CMP: begin
					if (shift_more) begin
						pos_q   <= pos_m1;
						state_q <= (pos_q == CW'(1)) ? S_ENQ_WR : S_ENQ_RD;
					end else begin
						state_q <= S_ENQ_WR;
					end
				end
				S_ENQ_WR: begin
					count_q <= count_q + CW'(1);
					state_q <= S_EMIT;
				end
				S_DEQ_WAIT: begin
					res_rec_q <= rd_data_q;
					head_q    <= phys(head_q, IW'(1));
					count_q   <= count_q - CW'(1);
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TR_RD: begin
					state_q <= S_TR_CUR;
				end
				S_TR_CUR: begin
					cur_q   <= rd_data_q;
					cnt_q   <= '0;
					j_q     <= i_p1;
					rdv_q   <= 1'b0;
					state_q <= S_TR_SCAN;
				end
				S_TR_SCAN: begin
					if (same_hit && cnt_q != mkpq_pkg::SAME_MAX) begin
						cnt_q <= cnt_q + mkpq_pkg::SAME_W'(1);
					end
					if (j_q < count_q) begin
						j_q   <= j_q + CW'(1);
						rdv_q <= 1'b1;
					end else begin
						rdv_q <= 1'b0;
						if (!rdv_q) begin
							state_q <= S_TR_OUT;
						end
					end
				end
				S_TR_OUT: begin
					if (out_free) begin
						i_q     <= i_p1;
						state_q <= tr_last ? S_IDLE : S_TR_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: valid is control state, the payload needs no reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == S_TR_OUT) begin
				status_q  <= mkpq_pkg::ST_OK;
				out_rec_q <= cur_q;
				same_q    <= cnt_q;
				last_q    <= tr_last;
			end else begin
				status_q  <= res_status_q;
				out_rec_q <= res_rec_q;
				same_q    <= '0;
				last_q    <= 1'b1;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign out_token          = out_rec_q.token;
	assign out_age            = out_rec_q.age;
	assign out_name_id        = out_rec_q.name_id;
	assign out_problem_id     = out_rec_q.problem_id;
	assign same_problem_later = same_q;
	assign last               = last_q;

endmodule

[src/mkpq_checker.sv]
// Port-level assertions of the min-key priority queue, bound to its top level.
module mkpq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [mkpq_pkg::STATUS_W-1:0] status,
	input logic [mkpq_pkg::TOKEN_W-1:0]  out_token,
	input logic [mkpq_pkg::AGE_W-1:0]    out_age,
	input logic [mkpq_pkg::ID_W-1:0]     out_name_id,
	input logic [mkpq_pkg::ID_W-1:0]     out_problem_id,
	input logic [mkpq_pkg::SAME_W-1:0]   same_problem_later,
	input logic                          last
);

	// A stalled result holds its status, token, problem id, same-problem count and last.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_token)
		&& $stable(out_problem_id) && $stable(same_problem_later) && $stable(last))
		else $error("stalled result changed");

	// Full and empty answers are always the only result of their command.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mkpq_pkg::ST_OK |-> last)
		else $error("error status without last");

	// Full and empty answers carry no record.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mkpq_pkg::ST_OK |-> out_token == '0 && out_age == '0
		&& out_name_id == '0 && out_problem_id == '0 && same_problem_later == '0)
		else $error("error status with record fields");

	// Only a traverse result that is not the last can see later records.
	a_same_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && same_problem_later != '0 |-> status == mkpq_pkg::ST_OK && !last)
		else $error("same-problem count on a final or error result");

endmodule

bind min_key_priority_queue_unit mkpq_checker u_mkpq_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_ready          (out_ready),
	.status             (status),
	.out_token          (out_token),
	.out_age            (out_age),
	.out_name_id        (out_name_id),
	.out_problem_id     (out_problem_id),
	.same_problem_later (same_problem_later),
	.last               (last)
);

[test/tb_min_key_priority_queue_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the min-key priority queue unit: directed table, then random traffic.
module tb_min_key_priority_queue_unit;
	import mkpq_pkg::*;

	localparam int QUEUE_DEPTH  = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 340;
	// The longest correct stretch without any transfer comes from a sender gap,
	// a receiver stall and one enqueue shift, so this limit is generous.
	localparam int IDLE_LIMIT   = 2000;
	// Cycles to watch the output after the last awaited result, to catch extras.
	localparam int DRAIN_CYCLES = 40;

	// One command as the sender presents it.
	typedef struct packed {
		logic [OP_W-1:0] op;
		record_t         rec;
	} queue_cmd_t;

	// One result as it should leave the output channel.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		record_t             rec;
		logic [SAME_W-1:0]   same;
		logic                last;
	} queue_reply_t;

	// A row of the directed table. Where fixed is set, the row carries its own
	// single expected status and the predictor's answer is not used for it.
	typedef struct packed {
		queue_cmd_t          cmd;
		logic                fixed;
		logic [STATUS_W-1:0] fixed_status;
	} table_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     operation;
	logic [TOKEN_W-1:0]  token;
	logic [AGE_W-1:0]    age;
	logic [ID_W-1:0]     name_id;
	logic [ID_W-1:0]     problem_id;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TOKEN_W-1:0]  out_token;
	logic [AGE_W-1:0]    out_age;
	logic [ID_W-1:0]     out_name_id;
	logic [ID_W-1:0]     out_problem_id;
	logic [SAME_W-1:0]   same_problem_later;
	logic                last;

	// Our own image of the queue contents, kept sorted like the block's memory.
	record_t      queue_image [QUEUE_DEPTH];
	int           image_count;
	// Results still to come, oldest first, and the answer to the latest command.
	queue_reply_t pending_replies [$];
	queue_reply_t fresh_replies [$];
	queue_reply_t want_reply;
	table_row_t   directed_rows [$];

	int unsigned fail_count  = 0;
	int unsigned idle_cycles = 0;
	int unsigned burst_left  = 0;
	int unsigned ready_left  = 0;
	int unsigned stall_left  = 0;
	logic        steady_sender = 1'b0;

	min_key_priority_queue_unit #(
		.DEPTH(QUEUE_DEPTH)
	) u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.operation         (operation),
		.token             (token),
		.age               (age),
		.name_id           (name_id),
		.problem_id        (problem_id),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.out_token         (out_token),
		.out_age           (out_age),
		.out_name_id       (out_name_id),
		.out_problem_id    (out_problem_id),
		.same_problem_later(same_problem_later),
		.last              (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one command to the queue image and leaves its results in
	// fresh_replies. A new record goes behind every record whose token is equal
	// or smaller, so records with equal tokens leave in arrival order.
	function automatic void predict_queue_reply(input queue_cmd_t c);
		int           pos;
		int           later;
		int           i;
		int           j;
		queue_reply_t r;
		r = '0;
		r.last = 1'b1;
		case (c.op)
			OP_ENQ: begin
				if (image_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = image_count;
					while (pos > 0 && queue_image[pos-1].token > c.rec.token) begin
						queue_image[pos] = queue_image[pos-1];
						pos--;
					end
					queue_image[pos] = c.rec;
					image_count++;
					r.status = ST_OK;
				end
				fresh_replies.push_back(r);
			end
			OP_DEQ: begin
				if (image_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.status = ST_OK;
					r.rec = queue_image[0];
					for (i = 1; i < image_count; i++)
						queue_image[i-1] = queue_image[i];
					image_count--;
				end
				fresh_replies.push_back(r);
			end
			OP_TRAV: begin
				if (image_count == 0) begin
					r.status = ST_EMPTY;
					fresh_replies.push_back(r);
				end else begin
					// Every held record in order; the count of later records with
					// the same problem id stops at its maximum.
					for (i = 0; i < image_count; i++) begin
						later = 0;
						for (j = i + 1; j < image_count; j++)
							if (queue_image[j].problem_id == queue_image[i].problem_id
									&& later < SAME_MAX)
								later++;
						r.status = ST_OK;
						r.rec = queue_image[i];
						r.same = SAME_W'(later);
						r.last = (i == image_count - 1);
						fresh_replies.push_back(r);
					end
				end
			end
			default: begin
				// The unused code is dropped without a result.
			end
		endcase
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] op, input logic [TOKEN_W-1:0] tk,
			input logic [AGE_W-1:0] ag, input logic [ID_W-1:0] nm,
			input logic [ID_W-1:0] pr, input logic fixed,
			input logic [STATUS_W-1:0] fixed_status);
		table_row_t row;
		row.cmd.op             = op;
		row.cmd.rec.token      = tk;
		row.cmd.rec.age        = ag;
		row.cmd.rec.name_id    = nm;
		row.cmd.rec.problem_id = pr;
		row.fixed              = fixed;
		row.fixed_status       = fixed_status;
		directed_rows.push_back(row);
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	// Presents one command and holds it until the transfer, then records what it
	// should produce. The sender works in bursts: when a burst is used up it
	// drops valid for a random gap, unless the current phase runs steady.
	task automatic send_command(input queue_cmd_t c, input logic fixed,
			input logic [STATUS_W-1:0] fixed_status);
		queue_reply_t r;
		if (burst_left == 0) begin
			if (!steady_sender) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		in_valid   <= 1'b1;
		operation  <= c.op;
		token      <= c.rec.token;
		age        <= c.rec.age;
		name_id    <= c.rec.name_id;
		problem_id <= c.rec.problem_id;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		fresh_replies.delete();
		predict_queue_reply(c);
		if (fixed) begin
			r = '0;
			r.status = fixed_status;
			r.last = 1'b1;
			pending_replies.push_back(r);
		end else begin
			foreach (fresh_replies[k])
				pending_replies.push_back(fresh_replies[k]);
		end
	endtask

	// Receiver: short ready stretches broken by stalls,
	// with now and then a long stretch of steady readiness.
	always @(posedge clk) begin
		if (ready_left == 0 && stall_left == 0) begin
			stall_left = $urandom_range(1, 5);
			ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
				: $urandom_range(0, 12);
		end
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			ready_left--;
		end
	end

	// Output checker and watchdog. Both sample the pre-edge values, so each
	// transfer is seen exactly at the edge where it happens.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: result with nothing awaited: status %0d token %h age %h",
					$time, status, out_token, out_age);
				$display("%0t:   name %h problem %h same %0d last %b", $time,
					out_name_id, out_problem_id, same_problem_later, last);
				fail_count++;
			end else begin
				want_reply = pending_replies.pop_front();
				check_field("status", 32'(want_reply.status), 32'(status));
				check_field("out_token", 32'(want_reply.rec.token), 32'(out_token));
				check_field("out_age", 32'(want_reply.rec.age), 32'(out_age));
				check_field("out_name_id", 32'(want_reply.rec.name_id), 32'(out_name_id));
				check_field("out_problem_id", 32'(want_reply.rec.problem_id),
					32'(out_problem_id));
				check_field("same_problem_later", 32'(want_reply.same),
					32'(same_problem_later));
				check_field("last", 32'(want_reply.last), 32'(last));
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("min_key_priority_queue_unit verification failed");
				$finish;
			end
		end
	end

	initial begin
		queue_cmd_t  c;
		int unsigned random_sent;
		int unsigned phase_idx;
		int unsigned phase_kind;
		int unsigned enq_cut;
		int unsigned deq_cut;
		int unsigned roll;
		int unsigned pick;

		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		operation  <= OP_ENQ;
		token      <= '0;
		age        <= '0;
		name_id    <= '0;
		problem_id <= '0;
		image_count = 0;
		random_sent = 0;
		phase_idx   = 0;

		// Directed part. The first rows hit the empty queue and the unused code;
		// then eight records that all share one problem id fill the queue, with
		// extreme tokens and fields and repeated tokens, so the first record of
		// the traverse has the saturated count. One more enqueue finds it full.
		add_row(OP_DEQ,    16'h0000, 7'h00, 16'h0000, 16'h0000, 1'b1, ST_EMPTY);
		add_row(OP_TRAV,   16'h0000, 7'h00, 16'h0000, 16'h0000, 1'b1, ST_EMPTY);
		add_row(OP_UNUSED, 16'hFFFF, 7'h7F, 16'hFFFF, 16'hFFFF, 1'b0, ST_OK);
		add_row(OP_ENQ,    16'hFFFF, 7'h7F, 16'hFFFF, 16'h0007, 1'b1, ST_OK);
		add_row(OP_ENQ,    16'h0000, 7'h00, 16'h0000, 16'h0007, 1'b1, ST_OK);
		add_row(OP_ENQ,    16'h8000, 7'h40, 16'h1234, 16'h0007, 1'b0, ST_OK);
		add_row(OP_ENQ,    16'h8000, 7'h01, 16'h5678, 16'h0007, 1'b0, ST_OK);
		add_row(OP_ENQ,    16'h0000, 7'h3F, 16'hAAAA, 16'h0007, 1'b0, ST_OK);
		add_row(OP_ENQ,    16'h7FFF, 7'h2A, 16'h5555, 16'h0007, 1'b0, ST_OK);
		add_row(OP_ENQ,    16'h8000, 7'h15, 16'h0F0F, 16'h0007, 1'b0, ST_OK);
		add_row(OP_ENQ,    16'h0001, 7'h55, 16'hF0F0, 16'h0007, 1'b0, ST_OK);
		add_row(OP_ENQ,    16'h1111, 7'h11, 16'h1111, 16'h1111, 1'b1, ST_FULL);
		add_row(OP_TRAV,   16'h0000, 7'h00, 16'h0000, 16'h0000, 1'b0, ST_OK);
		add_row(OP_DEQ,    16'h0000, 7'h00, 16'h0000, 16'h0000, 1'b0, ST_OK);
		add_row(OP_DEQ,    16'h0000, 7'h00, 16'h0000, 16'h0000, 1'b0, ST_OK);
		// A fresh smallest token must go to the head; mixed problem ids follow.
		add_row(OP_ENQ,    16'h0000, 7'h7F, 16'hFFFF, 16'hFFFF, 1'b0, ST_OK);
		add_row(OP_ENQ,    16'h8000, 7'h00, 16'h0000, 16'hFFFF, 1'b0, ST_OK);
		add_row(OP_TRAV,   16'h0000, 7'h00, 16'h0000, 16'h0000, 1'b0, ST_OK);
		add_row(OP_UNUSED, 16'h0000, 7'h00, 16'h0000, 16'h0000, 1'b0, ST_OK);
		add_row(OP_DEQ,    16'h0000, 7'h00, 16'h0000, 16'h0000, 1'b0, ST_OK);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[n])
			send_command(directed_rows[n].cmd, directed_rows[n].fixed,
				directed_rows[n].fixed_status);

		// Random part in phases. Each phase leans toward filling, draining,
		// mixing or traversing, so the queue swings between empty and full
		// many times. Half of the tokens come from a narrow range to force ties, and
		// problem ids mostly from a few values so the same-problem counts grow.
		while (random_sent < RANDOM_ITEMS) begin
			phase_kind    = $urandom_range(0, 3);
			steady_sender = ($urandom_range(0, 3) == 0);
			case (phase_kind)
				0: begin
					enq_cut = 70;
					deq_cut = 85;
				end
				1: begin
					enq_cut = 25;
					deq_cut = 80;
				end
				2: begin
					enq_cut = 45;
					deq_cut = 80;
				end
				default: begin
					enq_cut = 45;
					deq_cut = 60;
				end
			endcase
			// Now and then, and surely in the fifth phase, the sender holds off
			// until every awaited result has come out.
			if (phase_idx == 4 || $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_replies.size() != 0);
				burst_left = 0;
			end
			repeat ($urandom_range(8, 40)) begin
				roll = $urandom_range(0, 99);
				if (roll < enq_cut)
					c.op = OP_ENQ;
				else if (roll < deq_cut)
					c.op = OP_DEQ;
				else if (roll < 97)
					c.op = OP_TRAV;
				else
					c.op = OP_UNUSED;
				pick = $urandom_range(0, 19);
				if (pick < 10)
					c.rec.token = TOKEN_W'($urandom_range(0, 15));
				else if (pick < 17)
					c.rec.token = TOKEN_W'($urandom);
				else if (pick < 19)
					c.rec.token = '1;
				else
					c.rec.token = '0;
				c.rec.age     = AGE_W'($urandom_range(0, 127));
				c.rec.name_id = ID_W'($urandom);
				c.rec.problem_id = ($urandom_range(0, 4) < 3) ? ID_W'($urandom_range(0, 2))
					: ID_W'($urandom);
				send_command(c, 1'b0, ST_OK);
				if (c.op != OP_UNUSED)
					random_sent++;
			end
			phase_idx++;
		end

		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("min_key_priority_queue_unit verification clean");
		else
			$display("min_key_priority_queue_unit verification failed");
		$finish;
	end

endmodule
